// File: hdl/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types, constants and chip functions of the DSSS/CCK chip mapper.
// ----------------------------------------------------------------------------
package dcm_pkg;

  typedef enum logic [1:0] {
    FuncDbpsk = 2'd0,
    FuncDqpsk = 2'd1,
    FuncCck55 = 2'd2,
    FuncCck11 = 2'd3
  } func_e;

  localparam int unsigned ChipW   = 22;
  localparam int unsigned CountW  = 4;
  localparam int unsigned BarkerLen = 11;
  localparam int unsigned CckLen  = 8;

  localparam logic [CountW-1:0] BarkerCount = CountW'(BarkerLen);
  localparam logic [CountW-1:0] CckCount    = CountW'(CckLen);

  // Barker chips 1, 4, 8, 9 and 10 are inverted
  localparam logic [BarkerLen-1:0] BarkerNegMask = 11'h712;

  // Gray code for a dibit: 0->0, 1->1, 2->3, 3->2
  localparam logic [3:0][1:0] GrayMap = {2'd2, 2'd3, 2'd1, 2'd0};

  // input to the symbol unit
  typedef struct packed {
    func_e      func;
    logic [7:0] bits;     // remaining byte bits, next symbol in the LSBs
    logic [1:0] phase;    // running phase before this symbol
    logic       parity;
  } sym_req_t;

  // result of the symbol unit
  typedef struct packed {
    logic [1:0]        phase;   // running phase after this symbol
    logic [ChipW-1:0]  chips;
    logic [CountW-1:0] count;
  } sym_rsp_t;

  function automatic logic [ChipW-1:0] barker_chips(input logic [1:0] ph);
    logic [ChipW-1:0] c;
    c = '0;
    for (int k = 0; k < BarkerLen; k++) begin
      c[2*k +: 2] = BarkerNegMask[k] ? ph + 2'd2 : ph;
    end
    return c;
  endfunction

  function automatic logic [ChipW-1:0] cck_chips(input logic [1:0] p1,
                                                 input logic [1:0] p2,
                                                 input logic [1:0] p3,
                                                 input logic [1:0] p4);
    logic [ChipW-1:0] c;
    c = '0;
    c[1:0]   = p1 + p2 + p3 + p4;
    c[3:2]   = p1 + p3 + p4;
    c[5:4]   = p1 + p2 + p4;
    c[7:6]   = p1 + p4 + 2'd2;
    c[9:8]   = p1 + p2 + p3;
    c[11:10] = p1 + p3;
    c[13:12] = p1 + p2 + 2'd2;
    c[15:14] = p1;
    return c;
  endfunction

endpackage

// File: hdl/dsss_cck_chip_mapper.sv
// ----------------------------------------------------------------------------
// dsss_cck_chip_mapper
// Maps data bytes to differentially encoded Barker or CCK chip symbols.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                 | tuser                     | tlast
//  s_axis   | in  | [7:0] data_byte       | [1:0] func, [2] mode_chg  | -
//  m_axis   | out | [21:0] chip_phases    | [3:0] chip_count          | last_of_byte
//
//  A byte yields 8 (DBPSK), 4 (DQPSK), 2 (CCK 5.5) or 1 (CCK 11) symbols,
//  one per cycle through the shared symbol unit after the accept cycle
//  unless back-pressure holds the output register.
//  Input is ready only while the sequencer is idle; the output register
//  holds a symbol under back-pressure and the sequencer waits on it.
//  Reset clears the running phase, the symbol parity and all valid flags.
// ----------------------------------------------------------------------------
module dsss_cck_chip_mapper import dcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] mode_change
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [21:0] chip_phases, [23:22] zero
  output logic [3:0]  m_axis_tuser,   // [3:0] chip_count
  output logic        m_axis_tlast    // last_of_byte
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  func_e             func_q;
  logic [7:0]        byte_q, byte_d;
  logic [2:0]        rem_q, rem_d;      // symbols left after the current one
  logic [1:0]        phase_q, phase_d;
  logic              parity_q, parity_d;
  logic              out_valid_q, out_valid_d;
  logic [ChipW-1:0]  out_chips_q;
  logic [CountW-1:0] out_count_q;
  logic              out_last_q;

  logic     in_acc;
  logic     step;
  sym_req_t req;
  sym_rsp_t rsp;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign step          = (state_q == StRun) && (!out_valid_q || m_axis_tready);

  assign req.func   = func_q;
  assign req.bits   = byte_q;
  assign req.phase  = phase_q;
  assign req.parity = parity_q;

  dcm_sym_unit u_sym (
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    state_d     = state_q;
    byte_d      = byte_q;
    rem_d       = rem_q;
    phase_d     = phase_q;
    parity_d    = parity_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRun;
          byte_d  = s_axis_tdata;
          if (s_axis_tuser[2]) begin
            parity_d = 1'b0;
          end
          case (func_e'(s_axis_tuser[1:0]))
            FuncDbpsk: rem_d = 3'd7;
            FuncDqpsk: rem_d = 3'd3;
            FuncCck55: rem_d = 3'd1;
            default:   rem_d = 3'd0;
          endcase
        end
      end
      StRun: begin
        if (step) begin
          out_valid_d = 1'b1;
          phase_d     = rsp.phase;
          parity_d    = ~parity_q;
          rem_d       = rem_q - 3'd1;
          case (func_q)
            FuncDbpsk: byte_d = {1'b0, byte_q[7:1]};
            FuncDqpsk: byte_d = {2'b0, byte_q[7:2]};
            default:   byte_d = {4'b0, byte_q[7:4]};
          endcase
          if (rem_q == 3'd0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= 2'd0;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rem_q       <= 3'd0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (in_acc) begin
      func_q <= func_e'(s_axis_tuser[1:0]);
    end
    if (step) begin
      out_chips_q <= rsp.chips;
      out_count_q <= rsp.count;
      out_last_q  <= (rem_q == 3'd0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_chips_q};
  assign m_axis_tuser  = out_count_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // a symbol step always leaves a symbol in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("symbol step lost");

  // a taken byte starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StRun))
    else $error("byte accepted without run");

  // the final symbol of a byte returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (rem_q == 3'd0)) |=> (s_axis_tready && m_axis_tlast))
    else $error("sequencer did not finish with last symbol");

  // chip count is Barker or CCK length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == BarkerCount || m_axis_tuser == CckCount))
    else $error("bad chip count");
`endif

endmodule

// File: hdl/dcm_sym_unit.sv
// ----------------------------------------------------------------------------
// dcm_sym_unit
// Maps one symbol: advances the running phase and forms its chips.
// ----------------------------------------------------------------------------
module dcm_sym_unit import dcm_pkg::*; (
  input  sym_req_t req_i,
  output sym_rsp_t rsp_o
);

  logic [1:0] gray_ph;
  logic [1:0] new_ph;

  assign gray_ph = GrayMap[req_i.bits[1:0]];

  always_comb begin
    new_ph = req_i.phase;
    rsp_o  = '0;
    case (req_i.func)
      FuncDbpsk: begin
        new_ph      = req_i.phase + {req_i.bits[0], 1'b0};
        rsp_o.chips = barker_chips(new_ph);
        rsp_o.count = BarkerCount;
      end
      FuncDqpsk: begin
        new_ph      = req_i.phase + gray_ph;
        rsp_o.chips = barker_chips(new_ph);
        rsp_o.count = BarkerCount;
      end
      FuncCck55: begin
        // odd symbols rotated by pi
        new_ph      = req_i.phase + gray_ph + {req_i.parity, 1'b0};
        rsp_o.chips = cck_chips(new_ph, {req_i.bits[2], 1'b1}, 2'd0,
                                {req_i.bits[3], 1'b0});
        rsp_o.count = CckCount;
      end
      FuncCck11: begin
        new_ph      = req_i.phase + gray_ph;
        rsp_o.chips = cck_chips(new_ph, req_i.bits[3:2], req_i.bits[5:4],
                                req_i.bits[7:6]);
        rsp_o.count = CckCount;
      end
      default: begin
        new_ph = req_i.phase;
      end
    endcase
    rsp_o.phase = new_ph;
  end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DSSS/CCK chip mapper. A queue-fed driver sends
// bytes under all four modulations and a clocked monitor compares every
// symbol with a local model that tracks the running phase and symbol parity.
// Both sides idle in short random bursts, except near the end.
// ----------------------------------------------------------------------------
module tb_top import dcm_pkg::*; ();

  localparam int unsigned RandItems     = 208;
  localparam int unsigned TailItems     = 30;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned WatchdogLimit = 2000;

  // Barker sequence +1 -1 +1 +1 -1 +1 +1 +1 -1 -1 -1, set bit = inverted chip
  localparam logic [10:0] BarkerInvert = 11'b111_0001_0010;

  typedef struct {
    logic [7:0] payload;
    func_e      func;
    logic       mode_chg;
    logic       drain;     // hold this item back until every symbol is out
  } byte_req_t;

  typedef struct {
    logic [21:0] chips;
    logic [3:0]  count;
    logic        last;
  } chip_sym_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic [2:0]  s_axis_tuser = '0;   // [1:0] func, [2] mode_change
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [21:0] chip_phases, [23:22] zero
  logic [3:0]  m_axis_tuser;        // [3:0] chip_count
  logic        m_axis_tlast;        // last_of_byte

  byte_req_t   pending[$];
  chip_sym_t   chip_q[$];
  logic [1:0]  run_phase = 2'd0;
  logic        sym_parity = 1'b0;
  int unsigned n_fail = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned idle_cycles = 0;

  dsss_cck_chip_mapper dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [1:0] gray_phase(input logic [1:0] dibit);
    case (dibit)
      2'd0:    return 2'd0;
      2'd1:    return 2'd1;
      2'd2:    return 2'd3;
      default: return 2'd2;
    endcase
  endfunction

  function automatic logic [21:0] barker_word(input logic [1:0] ph);
    logic [21:0] w;
    w = '0;
    for (int k = 0; k < 11; k++) begin
      w[2*k +: 2] = ph ^ {BarkerInvert[k], 1'b0};
    end
    return w;
  endfunction

  function automatic logic [21:0] cck_word(input logic [1:0] p1, input logic [1:0] p2,
                                           input logic [1:0] p3, input logic [1:0] p4);
    logic [1:0] c [8];
    logic [21:0] w;
    c[0] = p1 + p2 + p3 + p4;
    c[1] = p1 + p3 + p4;
    c[2] = p1 + p2 + p4;
    c[3] = p1 + p4 + 2'd2;
    c[4] = p1 + p2 + p3;
    c[5] = p1 + p3;
    c[6] = p1 + p2 + 2'd2;
    c[7] = p1;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[2*k +: 2] = c[k];
    end
    return w;
  endfunction

  function automatic void push_sym(input logic [21:0] chips, input logic [3:0] count,
                                   input logic last);
    chip_sym_t s;
    s.chips = chips;
    s.count = count;
    s.last  = last;
    chip_q.push_back(s);
    sym_parity = ~sym_parity;
  endfunction

  function automatic void map_byte(input logic [7:0] pl, input func_e fn, input logic mc);
    logic [1:0] dp;
    logic [3:0] nib;
    if (mc) sym_parity = 1'b0;
    case (fn)
      FuncDbpsk: begin
        for (int i = 0; i < 8; i++) begin
          run_phase = run_phase + (pl[i] ? 2'd2 : 2'd0);
          push_sym(barker_word(run_phase), BarkerCount, i == 7);
        end
      end
      FuncDqpsk: begin
        for (int i = 0; i < 4; i++) begin
          run_phase = run_phase + gray_phase(pl[2*i +: 2]);
          push_sym(barker_word(run_phase), BarkerCount, i == 3);
        end
      end
      FuncCck55: begin
        for (int h = 0; h < 2; h++) begin
          nib = pl[4*h +: 4];
          dp  = gray_phase(nib[1:0]);
          if (sym_parity) dp = dp + 2'd2;  // odd symbols rotated by pi
          run_phase = run_phase + dp;
          push_sym(cck_word(run_phase, nib[2] ? 2'd3 : 2'd1, 2'd0, nib[3] ? 2'd2 : 2'd0),
                   CckCount, h == 1);
        end
      end
      default: begin
        run_phase = run_phase + gray_phase(pl[1:0]);
        push_sym(cck_word(run_phase, pl[3:2], pl[5:4], pl[7:6]), CckCount, 1'b1);
      end
    endcase
  endfunction

  task automatic add_item(input logic [7:0] pl, input func_e fn, input logic mc,
                          input logic drain);
    byte_req_t r;
    r.payload  = pl;
    r.func     = fn;
    r.mode_chg = mc;
    r.drain    = drain;
    pending.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR: %s got %0h expected %0h at %0t", what, got, want, $time);
    n_fail++;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    byte_req_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        map_byte(s_axis_tdata, func_e'(s_axis_tuser[1:0]), s_axis_tuser[2]);
        if (pending.size() >= TailItems && $urandom_range(0, 3) == 0)
          src_gap = $urandom_range(1, 3);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() > 0 && !(pending[0].drain && chip_q.size() != 0)) begin
          r = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= r.payload;
          s_axis_tuser  <= {r.mode_chg, r.func};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    chip_sym_t s;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (chip_q.size() == 0) begin
          report_mismatch("symbol with none pending", 32'(m_axis_tdata), '0);
        end else begin
          s = chip_q.pop_front();
          if (m_axis_tdata !== {2'b00, s.chips})
            report_mismatch("chip_phases", 32'(m_axis_tdata), 32'(s.chips));
          if (m_axis_tuser !== s.count)
            report_mismatch("chip_count", 32'(m_axis_tuser), 32'(s.count));
          if (m_axis_tlast !== s.last)
            report_mismatch("last_of_byte", 32'(m_axis_tlast), 32'(s.last));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (pending.size() >= TailItems && $urandom_range(0, 4) == 0)
          snk_gap = $urandom_range(1, 3);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("dsss_cck_chip_mapper verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    func_e      fn;
    func_e      prev_fn;
    logic       mc;

    // extremes and a mix per mode
    add_item(8'h00, FuncDbpsk, 1'b1, 1'b0);
    add_item(8'hFF, FuncDbpsk, 1'b0, 1'b0);
    add_item(8'hA5, FuncDbpsk, 1'b0, 1'b0);
    add_item(8'h00, FuncDqpsk, 1'b1, 1'b0);
    add_item(8'hFF, FuncDqpsk, 1'b0, 1'b0);
    add_item(8'h1B, FuncDqpsk, 1'b0, 1'b0);
    add_item(8'hE4, FuncDqpsk, 1'b0, 1'b0);
    add_item(8'h00, FuncCck55, 1'b1, 1'b0);
    add_item(8'hFF, FuncCck55, 1'b0, 1'b0);
    add_item(8'h5A, FuncCck55, 1'b0, 1'b0);
    add_item(8'hA5, FuncCck55, 1'b0, 1'b0);
    add_item(8'h00, FuncCck11, 1'b0, 1'b0);
    add_item(8'hFF, FuncCck11, 1'b0, 1'b0);
    add_item(8'h93, FuncCck11, 1'b0, 1'b0);
    // parity now odd: CCK 5.5 without mode change gets the pi rotation
    add_item(8'h3C, FuncCck55, 1'b0, 1'b1);
    add_item(8'hC3, FuncCck55, 1'b0, 1'b0);
    // mode change flag while staying in the same mode: parity only
    add_item(8'h69, FuncCck55, 1'b1, 1'b0);
    add_item(8'h96, FuncCck55, 1'b0, 1'b0);
    add_item(8'h6C, FuncCck11, 1'b1, 1'b0);
    add_item(8'h27, FuncDqpsk, 1'b1, 1'b0);
    add_item(8'h81, FuncDbpsk, 1'b0, 1'b0);
    add_item(8'h7E, FuncDbpsk, 1'b1, 1'b0);

    // mostly well-formed mode switches, with some missing or stray flags
    prev_fn = FuncDbpsk;
    for (int i = 0; i < RandItems; i++) begin
      fn = func_e'($urandom_range(0, 3));
      if (fn != prev_fn) mc = ($urandom_range(0, 9) != 0);
      else               mc = ($urandom_range(0, 7) == 0);
      add_item(8'($urandom_range(0, 255)), fn, mc, (i % 50) == 25);
      prev_fn = fn;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || s_axis_tvalid || chip_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("dsss_cck_chip_mapper verification clean");
    end else begin
      $display("dsss_cck_chip_mapper verification failed");
    end
    $finish;
  end

endmodule
